// ===== hdl/btnla_pkg.sv =====
`default_nettype none
package btnla_pkg;

    localparam int TimeW   = 32;
    localparam int FieldW  = 3;
    localparam int AddrW   = 4;
    localparam int DataW   = 32;

    localparam logic [1:0] REG_ENABLE       = 2'd0;
    localparam logic [1:0] REG_LOCKOUT      = 2'd1;
    localparam logic [1:0] REG_FIRST_REPEAT = 2'd2;
    localparam logic [1:0] REG_FAST_REPEAT  = 2'd3;

    localparam logic [TimeW-1:0] LOCKOUT_RESET      = 32'd250000;
    localparam logic [TimeW-1:0] FIRST_REPEAT_RESET = 32'd500000;
    localparam logic [TimeW-1:0] FAST_REPEAT_RESET  = 32'd100000;

    typedef struct packed {
        logic             enable;
        logic [TimeW-1:0] lockout_us;
        logic [TimeW-1:0] first_repeat_us;
        logic [TimeW-1:0] fast_repeat_us;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/button_lockout_autorepeat_core.sv =====
`default_nettype none
// channel   | ports                                        | accepted when
// ----------+----------------------------------------------+---------------------------
// sample in | s_valid s_ready s_now_us s_button_down s_ack_mask | s_valid && s_ready
// flags out | m_valid m_ready m_pressed_flags m_held_flags | m_valid && m_ready
// config    | psel penable pwrite paddr pwdata prdata pready | psel && penable && pwrite
//
// one request per cycle sustained while m_ready is high; m_valid rises once an accepted request
// has moved from the input register, through per-button subtract/compare, into the result register
// button state updates when a request moves from the input to the result register while enabled
// reset is synchronous, active low, and clears valid flags, button state and config to defaults
// a stalled result holds the request in the input register; s_ready stays high while
// the result register drains in the same cycle
module button_lockout_autorepeat_core #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [btnla_pkg::TimeW-1:0]     s_now_us,
    input  wire logic [btnla_pkg::FieldW-1:0]    s_button_down,
    input  wire logic [btnla_pkg::FieldW-1:0]    s_ack_mask,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [btnla_pkg::FieldW-1:0]    m_pressed_flags,
    output logic      [btnla_pkg::FieldW-1:0]    m_held_flags,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [btnla_pkg::AddrW-1:0]     paddr,
    input  wire logic [btnla_pkg::DataW-1:0]     pwdata,
    output logic      [btnla_pkg::DataW-1:0]     prdata,
    output logic                                 pready
);
    import btnla_pkg::*;

    cfg_t cfg;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [TimeW-1:0]  now_reg;
    logic [FieldW-1:0] down_reg;
    logic [FieldW-1:0] ack_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [FieldW-1:0] pressed_reg;
    logic [FieldW-1:0] held_reg;

    logic                   advance;
    logic                   step;
    logic [NUM_BUTTONS-1:0] pend_next;
    logic [NUM_BUTTONS-1:0] held_next;
    logic [FieldW-1:0]      pressed_out;
    logic [FieldW-1:0]      held_out;

    btnla_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign step    = advance && cfg.enable;
    assign s_ready = !in_valid_reg || advance;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        logic down_i;
        logic ack_i;
        // buttons beyond the sample fields always read as released
        if (i < FieldW) begin : g_in
            assign down_i = down_reg[i];
            assign ack_i  = ack_reg[i];
        end else begin : g_none
            assign down_i = 1'b0;
            assign ack_i  = 1'b0;
        end

        btnla_button u_btn (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .step         (step),
            .now_us       (now_reg),
            .down         (down_i),
            .ack          (ack_i),
            .cfg          (cfg),
            .pending_next (pend_next[i]),
            .held_next    (held_next[i])
        );
    end

    for (genvar j = 0; j < FieldW; j++) begin : g_out
        if (j < NUM_BUTTONS) begin : g_on
            assign pressed_out[j] = pend_next[j];
            assign held_out[j]    = held_next[j];
        end else begin : g_off
            assign pressed_out[j] = 1'b0;
            assign held_out[j]    = 1'b0;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg  <= s_now_us;
            down_reg <= s_button_down;
            ack_reg  <= s_ack_mask;
        end
        if (advance) begin
            pressed_reg <= pressed_out;
            held_reg    <= held_out;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pressed_flags = pressed_reg;
    assign m_held_flags    = held_reg;

endmodule
`default_nettype wire

// ===== hdl/btnla_regs.sv =====
`default_nettype none
module btnla_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [btnla_pkg::AddrW-1:0]   paddr,
    input  wire logic [btnla_pkg::DataW-1:0]   pwdata,
    output logic      [btnla_pkg::DataW-1:0]   prdata,
    output logic                               pready,
    output btnla_pkg::cfg_t                    cfg
);
    import btnla_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= 1'b1;
            cfg_reg.lockout_us      <= LOCKOUT_RESET;
            cfg_reg.first_repeat_us <= FIRST_REPEAT_RESET;
            cfg_reg.fast_repeat_us  <= FAST_REPEAT_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_ENABLE:       cfg_reg.enable          <= pwdata[0];
                REG_LOCKOUT:      cfg_reg.lockout_us      <= pwdata;
                REG_FIRST_REPEAT: cfg_reg.first_repeat_us <= pwdata;
                REG_FAST_REPEAT:  cfg_reg.fast_repeat_us  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENABLE:       prdata = {{(DataW-1){1'b0}}, cfg_reg.enable};
            REG_LOCKOUT:      prdata = cfg_reg.lockout_us;
            REG_FIRST_REPEAT: prdata = cfg_reg.first_repeat_us;
            REG_FAST_REPEAT:  prdata = cfg_reg.fast_repeat_us;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/btnla_button.sv =====
`default_nettype none
module btnla_button (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic [btnla_pkg::TimeW-1:0]   now_us,
    input  wire logic                          down,
    input  wire logic                          ack,
    input  wire btnla_pkg::cfg_t               cfg,
    output logic                               pending_next,
    output logic                               held_next
);
    import btnla_pkg::*;

    logic             pending_reg;
    logic             held_reg;
    logic [TimeW-1:0] last_accept_reg;
    logic [TimeW-1:0] hold_start_reg;
    logic [TimeW-1:0] last_repeat_reg;
    logic [TimeW-1:0] last_accept_next;
    logic [TimeW-1:0] hold_start_next;
    logic [TimeW-1:0] last_repeat_next;

    logic [TimeW-1:0] accept_gap;
    logic [TimeW-1:0] hold_len;
    logic [TimeW-1:0] since_repeat;
    logic             lockout_done;
    logic             repeat_due;

    assign accept_gap   = now_us - last_accept_reg;
    assign hold_len     = now_us - hold_start_reg;
    assign since_repeat = now_us - last_repeat_reg;
    assign lockout_done = accept_gap > cfg.lockout_us;
    // both limits compared in parallel, hold length picks one
    assign repeat_due   = (hold_len < cfg.first_repeat_us) ?
                          (since_repeat > cfg.first_repeat_us) :
                          (since_repeat > cfg.fast_repeat_us);

    always_comb begin
        pending_next     = pending_reg;
        held_next        = held_reg;
        last_accept_next = last_accept_reg;
        hold_start_next  = hold_start_reg;
        last_repeat_next = last_repeat_reg;
        if (step) begin
            if (ack) begin
                pending_next = 1'b0;
            end
            if (!down) begin
                pending_next = 1'b0;
                held_next    = 1'b0;
            end else if (!held_reg) begin
                if (lockout_done) begin
                    pending_next     = 1'b1;
                    held_next        = 1'b1;
                    last_accept_next = now_us;
                    hold_start_next  = now_us;
                    last_repeat_next = now_us;
                end
            end else if (repeat_due) begin
                pending_next     = 1'b1;
                last_repeat_next = now_us;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg     <= 1'b0;
            held_reg        <= 1'b0;
            last_accept_reg <= '0;
            hold_start_reg  <= '0;
            last_repeat_reg <= '0;
        end else begin
            pending_reg     <= pending_next;
            held_reg        <= held_next;
            last_accept_reg <= last_accept_next;
            hold_start_reg  <= hold_start_next;
            last_repeat_reg <= last_repeat_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/btnla_checker.sv =====
`default_nettype none
module btnla_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [btnla_pkg::FieldW-1:0]  m_pressed_flags,
    input wire logic [btnla_pkg::FieldW-1:0]  m_held_flags
);
    import btnla_pkg::*;

    // nothing is pending out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("result or input register not empty after reset");

    // a press event only exists for a button that is held
    a_pending_held: assert property (@(posedge aclk)
        m_valid |-> (m_pressed_flags & ~m_held_flags) == '0)
        else $error("pressed flag without held flag");

    // a stalled result keeps the input register full
    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && !s_ready |=> !s_ready || m_ready)
        else $error("input register drained while result stalled");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressed_flags)
                                && $stable(m_held_flags))
        else $error("result changed while stalled");

endmodule

bind button_lockout_autorepeat_core btnla_checker u_btnla_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pressed_flags (m_pressed_flags),
    .m_held_flags    (m_held_flags)
);
`default_nettype wire

// ===== tb/btnla_flag_checker.sv =====
module btnla_flag_checker
    import btnla_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [TimeW-1:0]  s_now_us,
    input  wire logic [FieldW-1:0] s_button_down,
    input  wire logic [FieldW-1:0] s_ack_mask,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [FieldW-1:0] m_pressed_flags,
    input  wire logic [FieldW-1:0] m_held_flags,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [AddrW-1:0]  paddr,
    input  wire logic [DataW-1:0]  pwdata,
    output int                     mismatch_cnt,
    output int                     waiting_cnt
);

    typedef struct packed {
        logic [FieldW-1:0] pressed;
        logic [FieldW-1:0] held;
    } flags_t;

    cfg_t              cfg;
    logic [FieldW-1:0] held_q;
    logic [FieldW-1:0] pend_q;
    logic [TimeW-1:0]  accept_at [FieldW];
    logic [TimeW-1:0]  hold_from [FieldW];
    logic [TimeW-1:0]  repeat_at [FieldW];
    flags_t            expected_flags_q [$];
    int                err_total = 0;

    // when enabled, advances the per-button state by one sample; returns the flags after it
    function automatic flags_t step_buttons(input logic [TimeW-1:0] now,
                                            input logic [FieldW-1:0] down,
                                            input logic [FieldW-1:0] ack);
        logic [TimeW-1:0] hold_len;
        logic [TimeW-1:0] since;
        logic [TimeW-1:0] limit;
        flags_t           f;
        if (cfg.enable) begin
            for (int b = 0; b < FieldW; b++) begin
                // ack goes first, a press or repeat below may set it again
                if (ack[b]) begin
                    pend_q[b] = 1'b0;
                end
                if (!down[b]) begin
                    pend_q[b] = 1'b0;
                    held_q[b] = 1'b0;
                end else if (!held_q[b]) begin
                    since = now - accept_at[b];
                    if (since > cfg.lockout_us) begin
                        pend_q[b]    = 1'b1;
                        held_q[b]    = 1'b1;
                        hold_from[b] = now;
                        repeat_at[b] = now;
                        accept_at[b] = now;
                    end
                end else begin
                    hold_len = now - hold_from[b];
                    since    = now - repeat_at[b];
                    limit    = (hold_len < cfg.first_repeat_us) ? cfg.first_repeat_us
                                                                : cfg.fast_repeat_us;
                    if (since > limit) begin
                        pend_q[b]    = 1'b1;
                        repeat_at[b] = now;
                    end
                end
            end
        end
        f.pressed = pend_q;
        f.held    = held_q;
        return f;
    endfunction

    always @(posedge aclk) begin : monitor
        flags_t want;
        if (!aresetn) begin
            cfg.enable          = 1'b1;
            cfg.lockout_us      = LOCKOUT_RESET;
            cfg.first_repeat_us = FIRST_REPEAT_RESET;
            cfg.fast_repeat_us  = FAST_REPEAT_RESET;
            held_q = '0;
            pend_q = '0;
            for (int b = 0; b < FieldW; b++) begin
                accept_at[b] = '0;
                hold_from[b] = '0;
                repeat_at[b] = '0;
            end
            expected_flags_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ENABLE:       cfg.enable          = pwdata[0];
                    REG_LOCKOUT:      cfg.lockout_us      = pwdata;
                    REG_FIRST_REPEAT: cfg.first_repeat_us = pwdata;
                    REG_FAST_REPEAT:  cfg.fast_repeat_us  = pwdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_flags_q.push_back(step_buttons(s_now_us, s_button_down, s_ack_mask));
            end
            if (m_valid && m_ready) begin
                if (expected_flags_q.size() == 0) begin
                    $display("%0t checker: result with no request outstanding, pressed %b held %b",
                             $time, m_pressed_flags, m_held_flags);
                    err_total++;
                end else begin
                    want = expected_flags_q.pop_front();
                    if (m_pressed_flags !== want.pressed) begin
                        $display("%0t checker: pressed_flags expected %b got %b",
                                 $time, want.pressed, m_pressed_flags);
                        err_total++;
                    end
                    if (m_held_flags !== want.held) begin
                        $display("%0t checker: held_flags expected %b got %b",
                                 $time, want.held, m_held_flags);
                        err_total++;
                    end
                end
            end
        end
        waiting_cnt  <= expected_flags_q.size();
        mismatch_cnt <= err_total;
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import btnla_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [TimeW-1:0]  s_now_us = '0;
    logic [FieldW-1:0] s_button_down = '0;
    logic [FieldW-1:0] s_ack_mask = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [FieldW-1:0] m_pressed_flags;
    logic [FieldW-1:0] m_held_flags;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [AddrW-1:0]  paddr = '0;
    logic [DataW-1:0]  pwdata = '0;
    logic [DataW-1:0]  prdata;
    logic              pready;

    int                mismatch_cnt;
    int                waiting_cnt;
    int                send_idle_pct = 14;
    int                recv_idle_pct = 66;
    logic [TimeW-1:0]  sample_time = '0;
    logic [FieldW-1:0] button_levels = '0;

    button_lockout_autorepeat_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_now_us        (s_now_us),
        .s_button_down   (s_button_down),
        .s_ack_mask      (s_ack_mask),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pressed_flags (m_pressed_flags),
        .m_held_flags    (m_held_flags),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    btnla_flag_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_now_us        (s_now_us),
        .s_button_down   (s_button_down),
        .s_ack_mask      (s_ack_mask),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pressed_flags (m_pressed_flags),
        .m_held_flags    (m_held_flags),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_cnt    (mismatch_cnt),
        .waiting_cnt     (waiting_cnt)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_sample(input logic [TimeW-1:0] now, input logic [FieldW-1:0] down,
                               input logic [FieldW-1:0] ack);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_now_us      <= now;
        s_button_down <= down;
        s_ack_mask    <= ack;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding request to come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (waiting_cnt != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DataW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_timing(input logic [DataW-1:0] lock, input logic [DataW-1:0] first,
                              input logic [DataW-1:0] fast);
        drain();
        apb_write(REG_LOCKOUT, lock);
        apb_write(REG_FIRST_REPEAT, first);
        apb_write(REG_FAST_REPEAT, fast);
    endtask

    task automatic set_enable(input logic on);
        drain();
        apb_write(REG_ENABLE, {{(DataW-1){1'b0}}, on});
    endtask

    // mostly a clock that moves forward with buttons held for stretches,
    // with some fully random samples mixed in
    task automatic run_random(input int n, input int step_max, input int pause_at);
        logic [FieldW-1:0] ack_bits;
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) begin
                drain();
            end
            if ($urandom_range(0, 99) < 8) begin
                send_sample($urandom(), FieldW'($urandom_range(0, 7)),
                            FieldW'($urandom_range(0, 7)));
            end else begin
                if ($urandom_range(0, 49) == 0) begin
                    sample_time += $urandom();
                end else begin
                    sample_time += $urandom_range(0, step_max);
                end
                for (int b = 0; b < FieldW; b++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        button_levels[b] = ~button_levels[b];
                    end
                end
                ack_bits = ($urandom_range(0, 3) == 0) ? FieldW'($urandom_range(0, 7)) : '0;
                send_sample(sample_time, button_levels, ack_bits);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timing: lockout, repeat thresholds, release and wrap
        send_sample(32'd0, 3'b000, 3'b000);
        send_sample(32'd0, 3'b111, 3'b000);
        send_sample(32'd250000, 3'b001, 3'b000);
        send_sample(32'd250001, 3'b001, 3'b000);
        send_sample(32'd650001, 3'b001, 3'b001);
        send_sample(32'd750001, 3'b001, 3'b000);
        send_sample(32'd850001, 3'b001, 3'b001);
        send_sample(32'd850002, 3'b001, 3'b000);
        send_sample(32'd850002, 3'b000, 3'b000);
        send_sample(32'd900000, 3'b010, 3'b000);
        send_sample(32'd900010, 3'b000, 3'b000);
        send_sample(32'd900020, 3'b010, 3'b000);
        send_sample(32'd1150000, 3'b010, 3'b000);
        send_sample(32'd1150001, 3'b010, 3'b000);
        send_sample(32'hFFFF_FFF0, 3'b110, 3'b000);
        send_sample(32'h0001_0000, 3'b110, 3'b100);
        send_sample(32'h0008_0000, 3'b110, 3'b000);
        send_sample(32'hFFFF_FFFF, 3'b111, 3'b111);
        send_sample(32'h0000_0000, 3'b111, 3'b111);
        send_sample(32'hAAAA_AAAA, 3'b101, 3'b010);
        send_sample(32'h5555_5555, 3'b010, 3'b101);
        send_sample(32'h5555_5556, 3'b000, 3'b111);

        // disabled: samples and acks must leave the flags alone
        send_sample(32'h0100_0000, 3'b111, 3'b000);
        set_enable(1'b0);
        send_sample(32'h0200_0000, 3'b000, 3'b111);
        send_sample(32'h0300_0000, 3'b101, 3'b111);
        set_enable(1'b1);

        set_timing($urandom_range(0, 40), $urandom_range(0, 80), $urandom_range(0, 25));
        run_random(400, 12, 200);

        drain();
        send_idle_pct = 66;
        recv_idle_pct <= 14;
        set_timing('0, '0, '0);
        run_random(100, 12, -1);
        set_timing('1, '1, '1);
        run_random(100, 12, -1);
        set_enable(1'b0);
        run_random(50, 12, -1);
        set_enable(1'b1);
        set_timing($urandom_range(0, 40), $urandom_range(0, 80), $urandom_range(0, 25));
        run_random(200, 12, -1);

        drain();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_timing($urandom_range(0, 40), $urandom_range(0, 80), $urandom_range(0, 25));
        run_random(200, 12, -1);
        set_timing($urandom_range(0, 20), $urandom_range(0, 40), $urandom_range(0, 10));
        run_random(200, 6, -1);

        drain();
        if (mismatch_cnt == 0 && waiting_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/btnla_pkg.sv
hdl/btnla_regs.sv
hdl/btnla_button.sv
hdl/button_lockout_autorepeat_core.sv
hdl/btnla_checker.sv
tb/btnla_flag_checker.sv
tb/tb.sv
